// ===== hdl/slab_free_list_allocator_defines.svh =====
// Assertion macros for the slab free-list allocator.
// Included by the top level; no other dependencies.
`ifndef SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slab allocator check failed");

// next-cycle implication, disabled in reset
`define SFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slab allocator check failed");

`endif

// ===== hdl/slabfl_pkg.sv =====
// Shared types, widths and codes for the slab free-list allocator.
// No dependencies; used by slabfl_div, slab_free_list_allocator and the testbench.
package slabfl_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int CNT_W     = 12;
  localparam int LINK_W    = 12;
  localparam int IDX_OUT_W = 11;
  localparam int QUO_W     = CNT_W;
  localparam int PROD_W    = CNT_W + SIZE_W;
  localparam int STEP_W    = $clog2(QUO_W);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // config register index, byte address is index * 4
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_AREAD,
    S_AWB,
    S_FMUL,
    S_FCHK,
    S_FDIV,
    S_FPUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/slabfl_div.sv =====
// Restoring divider, one quotient bit per cycle, for the free-path slot index.
// Depends on slabfl_pkg. Quotient is known to fit QUO_W bits.
module slabfl_div
  import slabfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [QUO_W-1:0]  quotient
);

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsh;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic              ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the last quotient bit
      done <= busy && !start && (cnt == '0);
      if (start) begin
        rem  <= dividend;
        dsh  <= PROD_W'(divisor) << (QUO_W - 1);
        cnt  <= STEP_W'(QUO_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        dsh      <= dsh >> 1;
        quotient <= {quotient[QUO_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

// ===== hdl/slab_free_list_allocator.sv =====
// Slab free-list allocator: link store, head, free count, APB config registers.
// Depends on slabfl_pkg, slabfl_div and slab_free_list_allocator_defines.svh.
// Steps, accept to result: alloc reads, multiplies and writes back; free does the range
// multiply and check, the divider, then the push; failures skip ahead to the result.
// One item at a time; the next is accepted the cycle after its result loads.
// Reset and every config write start a clearing pass over all MAX_SLOTS chain links.
`include "slab_free_list_allocator_defines.svh"

module slab_free_list_allocator
  import slabfl_pkg::*;
#(
  parameter int MAX_SLOTS = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [ADDR_W-1:0]    address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [ADDR_W-1:0]    slot_address,
  output logic [IDX_OUT_W-1:0] slot_index,
  output logic                 has_free,
  output logic                 has_allocated,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = $clog2(MAX_SLOTS);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] slot_size;
  logic [CNT_W-1:0]  slot_count;
  logic [CNT_W-1:0]  n_eff;
  logic [SIZE_W-1:0] size_eff;

  logic [LINK_W-1:0] links [MAX_SLOTS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [LINK_W-1:0] link_rd;

  logic [AW-1:0]     clr_cnt;
  logic              clr_last;
  logic [CNT_W-1:0]  free_head;
  logic [CNT_W-1:0]  free_count;

  logic [ADDR_W-1:0] addr_q;
  logic              res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [CNT_W-1:0]  res_index;

  logic [CNT_W-1:0]  mul_a;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W:0]   last;
  logic              in_range;
  logic [ADDR_W-1:0] offset;

  logic              div_start;
  div_stat_t         div_stat;
  logic [QUO_W-1:0]  quo;
  logic              idx_ok;

  logic              cfg_wr;
  logic              out_load;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    n_eff    = (32'(slot_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : slot_count;
    size_eff = (slot_size == '0) ? SIZE_W'(1) : slot_size;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      slot_size    <= SIZE_W'(16);
      slot_count   <= CNT_W'(227);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASE:  base_address <= pwdata;
        REG_SIZE:  slot_size    <= pwdata[SIZE_W-1:0];
        REG_COUNT: slot_count   <= pwdata[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE:  prdata = base_address;
      REG_SIZE:  prdata = 32'(slot_size);
      REG_COUNT: prdata = 32'(slot_count);
      default:   prdata = '0;
    endcase
  end

  // link store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[mem_waddr] <= mem_wdata;
    end
    link_rd <= links[AW'(free_head)];
  end

  // shared multiplier: head * size for alloc, (n - 1) * size for the free range check
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(size_eff);
  end

  assign last     = {1'b0, base_address} + (ADDR_W + 1)'(prod);
  assign in_range = (addr_q >= base_address) && ({1'b0, addr_q} <= last);
  assign offset   = addr_q - base_address;
  assign clr_last = (clr_cnt == AW'(MAX_SLOTS - 1));
  assign idx_ok   = (quo < n_eff);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  slabfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (PROD_W'(offset)),
    .divisor  (size_eff),
    .stat     (div_stat),
    .quotient (quo)
  );

  always_comb begin
    state_next = state;
    if (cfg_wr) begin
      state_next = S_CLR;
    end else begin
      unique case (state)
        S_CLR:   if (clr_last) state_next = S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            if (mode == MODE_ALLOC) begin
              state_next = (free_head < n_eff) ? S_AREAD : S_DONE;
            end else begin
              state_next = (n_eff != '0) ? S_FMUL : S_DONE;
            end
          end
        end
        S_AREAD: state_next = S_AWB;
        S_AWB:   state_next = S_DONE;
        S_FMUL:  state_next = S_FCHK;
        S_FCHK:  state_next = in_range ? S_FDIV : S_DONE;
        S_FDIV:  if (div_stat.done) state_next = S_FPUSH;
        S_FPUSH: state_next = S_DONE;
        S_DONE:  if (out_load) state_next = S_IDLE;
        default: state_next = S_CLR;
      endcase
    end
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    mul_a     = (state == S_FMUL) ? (n_eff - 1'b1) : free_head;
    div_start = (state == S_FCHK) && in_range;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = LINK_W'(32'(clr_cnt) + 32'd1);
    unique case (state)
      S_CLR:   mem_we = 1'b1;
      S_FPUSH: begin
        mem_we    = idx_ok;
        mem_waddr = AW'(quo);
        mem_wdata = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      free_head  <= '0;
      free_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (!cfg_wr && out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        clr_cnt   <= '0;
        free_head <= '0;
      end else begin
        unique case (state)
          S_CLR: begin
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_last) begin
              free_count <= n_eff;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              addr_q     <= address;
              res_status <= ST_FAIL;
              res_addr   <= '0;
              res_index  <= '0;
            end
          end
          S_AWB: begin
            res_status <= ST_OK;
            res_addr   <= base_address + ADDR_W'(prod);
            res_index  <= free_head;
            free_head  <= link_rd;
            if (free_count != '0) begin
              free_count <= free_count - 1'b1;
            end
          end
          S_FPUSH: begin
            if (idx_ok) begin
              res_status <= ST_OK;
              res_index  <= quo;
              free_head  <= quo;
              if (free_count < n_eff) begin
                free_count <= free_count + 1'b1;
              end
            end
          end
          S_DONE: begin
            if (out_load) begin
              status        <= res_status;
              slot_address  <= res_addr;
              slot_index    <= res_index[IDX_OUT_W-1:0];
              has_free      <= (free_head < n_eff);
              has_allocated <= (free_count != n_eff);
            end
          end
          default: ;
        endcase
      end
    end
  end

  `SFA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != S_IDLE)
  `SFA_ASSERT_NOW(a_result_from_done, clk, rst, $rose(out_valid), $past(state == S_DONE))
  `SFA_ASSERT_NOW(a_count_bounded, clk, rst, state != S_CLR, free_count <= n_eff)

endmodule

// ===== tb/sv/tb_slab_free_list_allocator.sv =====
// Testbench for slab_free_list_allocator: directed and random alloc/free items,
// checked against an in-bench free-list predictor. Needs slabfl_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_slab_free_list_allocator
  import slabfl_pkg::*;
();

  localparam int SLOTS_MAX = 2048;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int RANDOM_PHASES = 11;

  localparam logic [1:0] REG_SPARE = 2'd3;  // no register here, write still rebuilds

  typedef struct packed {
    logic                 status;
    logic [ADDR_W-1:0]    slot_address;
    logic [IDX_OUT_W-1:0] slot_index;
    logic                 has_free;
    logic                 has_allocated;
  } slab_result_t;

  class slab_scoreboard;
    logic [31:0]  base;
    logic [12:0]  slot_bytes;
    logic [11:0]  slot_total;
    logic [11:0]  links[SLOTS_MAX];
    logic [11:0]  head;
    logic [11:0]  nfree;
    slab_result_t pending_q[$];
    int           errors;

    function int unsigned live_count();
      int unsigned c;
      c = slot_total;
      return (c > SLOTS_MAX) ? SLOTS_MAX : c;
    endfunction

    function int unsigned live_size();
      return (slot_bytes == 0) ? 1 : slot_bytes;
    endfunction

    function void rebuild();
      for (int i = 0; i < SLOTS_MAX; i++) links[i] = 12'(i + 1);
      head = '0;
      nfree = 12'(live_count());
    endfunction

    function void reset_state();
      base = '0;
      slot_bytes = 13'd16;
      slot_total = 12'd227;
      errors = 0;
      rebuild();
    endfunction

    function void write_register(logic [3:0] addr, logic [31:0] value);
      case (addr[3:2])
        REG_BASE:  base = value;
        REG_SIZE:  slot_bytes = value[12:0];
        REG_COUNT: slot_total = value[11:0];
        default: ;
      endcase
      rebuild();
    endfunction

    // predicts one accepted item and queues its result
    function slab_result_t note_request(logic m, logic [31:0] a);
      int unsigned     n;
      int unsigned     sz;
      int unsigned     idx;
      longint unsigned last_start;
      slab_result_t    r;
      n = live_count();
      sz = live_size();
      r = '0;
      r.status = ST_FAIL;
      if (m == MODE_ALLOC) begin
        if (head < n) begin
          r.slot_index = head[10:0];
          r.slot_address = base + 32'(head) * 32'(sz);
          head = links[head];
          if (nfree > 0) nfree = nfree - 12'd1;
          r.status = ST_OK;
        end
      end else if (n > 0) begin
        // range check without wrap at the top
        last_start = {32'h0, base} + 64'(n - 1) * 64'(sz);
        if (a >= base && {32'h0, a} <= last_start) begin
          idx = (a - base) / sz;
          if (idx < n) begin
            links[idx] = head;
            head = 12'(idx);
            if (nfree < n) nfree = nfree + 12'd1;
            r.slot_index = idx[10:0];
            r.status = ST_OK;
          end
        end
      end
      r.has_free = (head < n);
      r.has_allocated = (nfree != n);
      pending_q.push_back(r);
      return r;
    endfunction

    function void check_result(slab_result_t got);
      slab_result_t want;
      if (pending_q.size() == 0) begin
        $error("result with no item pending: %p", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot_address !== want.slot_address) begin
        $error("slot_address expected %h got %h", want.slot_address, got.slot_address);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index expected %0d got %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.has_free !== want.has_free) begin
        $error("has_free expected %0d got %0d", want.has_free, got.has_free);
        errors++;
      end
      if (got.has_allocated !== want.has_allocated) begin
        $error("has_allocated expected %0d got %0d", want.has_allocated,
               got.has_allocated);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 mode = MODE_ALLOC;
  logic [ADDR_W-1:0]    address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 status;
  logic [ADDR_W-1:0]    slot_address;
  logic [IDX_OUT_W-1:0] slot_index;
  logic                 has_free;
  logic                 has_allocated;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  slab_free_list_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .address(address),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .slot_address(slot_address), .slot_index(slot_index), .has_free(has_free),
    .has_allocated(has_allocated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  slab_scoreboard sb = new();
  logic [31:0]    live_slots[$];
  int             burst_left = 1;
  int             cycle_count = 0;
  int             ready_mode = 0;
  int             ready_left = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: switches between always ready, coin flip and long stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(20, 300);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      sb.check_result('{status, slot_address, slot_index, has_free, has_allocated});
    end
  end

  task automatic send(logic m, logic [31:0] a);
    slab_result_t p;
    int           gap;
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    do @(posedge clk); while (in_ready !== 1'b1);
    p = sb.note_request(m, a);
    if (m == MODE_ALLOC && p.status == ST_OK) live_slots.push_back(p.slot_address);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drain all results and wait until the block takes items again
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0 || in_ready !== 1'b1);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_register(addr, data);
  endtask

  // upper bits of the narrow registers carry junk; the block keeps the low bits
  task automatic configure(logic [31:0] b, logic [12:0] sz, logic [11:0] cnt,
                           bit touch_spare);
    apb_write({REG_BASE, 2'b00}, b);
    apb_write({REG_SIZE, 2'b00}, ($urandom() & ~32'h1FFF) | 32'(sz));
    apb_write({REG_COUNT, 2'b00}, ($urandom() & ~32'hFFF) | 32'(cnt));
    if (touch_spare) apb_write({REG_SPARE, 2'b00}, $urandom());
    live_slots.delete();
  endtask

  task automatic random_item();
    int unsigned     n;
    int unsigned     sz;
    int unsigned     k;
    int              pick;
    longint unsigned last_start;
    logic [31:0]     a;
    n = sb.live_count();
    sz = sb.live_size();
    pick = $urandom_range(0, 99);
    a = $urandom();
    if (pick < 45) begin
      send(MODE_ALLOC, a);
    end else if (pick < 78 && live_slots.size() > 0) begin
      k = $urandom_range(0, live_slots.size() - 1);
      a = live_slots[k];
      live_slots.delete(k);
      send(MODE_FREE, a);
    end else begin
      if (n > 0) begin
        last_start = {32'h0, sb.base} + 64'(n - 1) * 64'(sz);
        case ($urandom_range(0, 4))
          0: a = sb.base + $urandom_range(0, n - 1) * sz;  // may be a double free
          1: a = sb.base + $urandom_range(0, n - 1) * sz + $urandom_range(0, sz - 1);
          2: if (sb.base != 0) a = sb.base - 1 - $urandom_range(0, 3);
          3: if (last_start < 64'hFFFF_FFFF) a = last_start[31:0] + 1 + $urandom_range(0, 3);
          default: ;
        endcase
      end
      send(MODE_FREE, a);
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 227 slots of 16 bytes at 0
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'hFFFF_FFFF);
    send(MODE_FREE, 32'd16);
    send(MODE_FREE, 32'd16);             // double free
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_FREE, 32'h0000_001C);      // unaligned
    send(MODE_FREE, 32'd226 * 32'd16);   // last slot
    send(MODE_FREE, 32'd227 * 32'd16);   // just past it
    send(MODE_FREE, 32'hFFFF_FFFF);

    // zero size acts as one byte, two slots
    configure(32'h0000_1000, 13'd0, 12'd2, 1'b0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);             // list empty
    send(MODE_FREE, 32'h0000_0FFF);      // below base
    send(MODE_FREE, 32'h0000_1001);
    send(MODE_FREE, 32'h0000_1002);      // above last slot
    send(MODE_FREE, 32'h0000_1000);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);

    // no slots at all
    configure(32'h8000_0000, 13'd16, 12'd0, 1'b0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_FREE, 32'h8000_0000);

    // clamped count, widest size, addresses wrap past the top
    configure(32'hFFFF_FFFF, 13'h1FFF, 12'hFFF, 1'b1);
    send(MODE_ALLOC, 32'h0);
    send(MODE_ALLOC, 32'h0);
    send(MODE_FREE, 32'hFFFF_FFFF);
    send(MODE_FREE, 32'h0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure($urandom(), 13'd1, 12'd1, 1'b0);
        1: configure($urandom(), 13'h1FFF, 12'd3, 1'b0);
        2: configure(32'h0, 13'd0, 12'd5, 1'b0);
        3: configure(32'hFFFF_FFFF, 13'd1, 12'd8, 1'b0);
        4: configure($urandom(), 13'd4096, 12'd2048, 1'b0);
        5: configure($urandom(), 13'($urandom_range(1, 64)), 12'hFFF, 1'b0);
        6: configure($urandom(), 13'($urandom()), 12'd0, 1'b1);
        default: configure($urandom(), 13'($urandom_range(1, 300)),
                           12'($urandom_range(1, 12)), 1'b0);
      endcase
      repeat (ITEMS_PER_PHASE) random_item();
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
